// File: rtl/load_store_address_generator_defines.svh
// assertion macros shared by the load/store address generator checker
`ifndef LOAD_STORE_ADDRESS_GENERATOR_DEFINES_SVH
`define LOAD_STORE_ADDRESS_GENERATOR_DEFINES_SVH

// overlapping implication, checked only out of reset
`define LSAG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lsag assertion failed");

// next-cycle implication, checked only out of reset
`define LSAG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsag assertion failed");

// next-cycle implication, also checked while reset is applied
`define LSAG_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("lsag reset assertion failed");

`endif

// File: rtl/lsag_pkg.sv
// types and codes for the load/store address generator
package lsag_pkg;

    // instruction classes
    localparam logic [1:0] OP_SINGLE = 2'd0;
    localparam logic [1:0] OP_HALF   = 2'd1;
    localparam logic [1:0] OP_MULTI  = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [3:0] LINK_REG = 4'd14;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef enum logic [4:0] {
        KIND_STR   = 5'd0,
        KIND_LDR   = 5'd1,
        KIND_STRT  = 5'd2,
        KIND_LDRT  = 5'd3,
        KIND_STRB  = 5'd4,
        KIND_LDRB  = 5'd5,
        KIND_STRBT = 5'd6,
        KIND_LDRBT = 5'd7,
        KIND_STRH  = 5'd8,
        KIND_LDRD  = 5'd9,
        KIND_STRD  = 5'd10,
        KIND_LDRH  = 5'd11,
        KIND_LDRSB = 5'd12,
        KIND_LDRSH = 5'd13,
        KIND_STM1  = 5'd14,
        KIND_LDM1  = 5'd15,
        KIND_STM2  = 5'd16,
        KIND_LDM2  = 5'd17,
        KIND_LDM3  = 5'd18
    } t_kind;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] instruction;
        logic [31:0] base_value;
        logic [31:0] offset_value;
        logic        carry_flag;
    } t_req;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] end_address;
        logic [31:0] new_base;
        logic        base_write;
        logic [3:0]  base_reg;
        logic [3:0]  data_reg;
        logic [4:0]  access_kind;
        logic [4:0]  transfer_count;
        logic        undefined;
        logic        unpredictable;
    } t_res;

endpackage

// File: rtl/lsag_shift.sv
// barrel shifter for register-scaled offsets (lsl, lsr, asr, ror, rrx)
module lsag_shift (
    input  lsag_pkg::t_shift i_kind,
    input  logic [4:0]       i_amt,
    input  logic [31:0]      i_value,
    input  logic             i_carry,
    output logic [31:0]      o_value
);
    import lsag_pkg::*;

    logic [5:0] rot_left;

    assign rot_left = 6'd32 - {1'b0, i_amt};

    always_comb begin
        case (i_kind)
            SH_LSL: begin
                o_value = i_value << i_amt;
            end
            SH_LSR: begin
                // amount zero encodes a shift by 32
                o_value = (i_amt == 5'd0) ? 32'd0 : (i_value >> i_amt);
            end
            SH_ASR: begin
                o_value = (i_amt == 5'd0) ? {32{i_value[31]}}
                                          : 32'($signed(i_value) >>> i_amt);
            end
            SH_ROR: begin
                // amount zero is rotate right extended through carry
                o_value = (i_amt == 5'd0) ? {i_carry, i_value[31:1]}
                                          : ((i_value >> i_amt) | (i_value << rot_left));
            end
            default: begin
                o_value = i_value;
            end
        endcase
    end

endmodule

// File: rtl/lsag_calc.sv
// decode and address arithmetic for one load/store request
module lsag_calc (
    input  lsag_pkg::t_req i_req,
    output lsag_pkg::t_res o_res
);
    import lsag_pkg::*;

    function automatic logic [2:0] pop4(input logic [3:0] v);
        pop4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
    endfunction

    logic [31:0] ins;
    logic [31:0] base;
    logic        p, u, b22, w, l;
    logic [3:0]  rd;
    logic [31:0] scaled;
    logic [31:0] off_single;
    logic [31:0] sum_single;
    logic [31:0] off_half;
    logic [31:0] sum_half;
    logic [4:0]  list_cnt;
    logic [31:0] span;
    logic [31:0] span_m4;
    logic [31:0] m_addr;
    logic [31:0] m_end;
    logic [31:0] m_base;
    logic [2:0]  hsel;
    logic [2:0]  msel;

    assign ins  = i_req.instruction;
    assign base = i_req.base_value;
    assign p    = ins[24];
    assign u    = ins[23];
    assign b22  = ins[22];
    assign w    = ins[21];
    assign l    = ins[20];
    assign rd   = ins[15:12];

    lsag_shift u_shift (
        .i_kind  (t_shift'(ins[6:5])),
        .i_amt   (ins[11:7]),
        .i_value (i_req.offset_value),
        .i_carry (i_req.carry_flag),
        .o_value (scaled)
    );

    // single word/byte offset and sum
    assign off_single = ins[25] ? scaled : {20'd0, ins[11:0]};
    assign sum_single = u ? (base + off_single) : (base - off_single);

    // halfword/doubleword offset and sum
    assign off_half = b22 ? {24'd0, ins[11:8], ins[3:0]} : i_req.offset_value;
    assign sum_half = u ? (base + off_half) : (base - off_half);

    // multiple: register list size, span in bytes
    assign list_cnt = 5'(pop4(ins[3:0])) + 5'(pop4(ins[7:4]))
                    + 5'(pop4(ins[11:8])) + 5'(pop4(ins[15:12]));
    assign span     = {25'd0, list_cnt, 2'b00};
    assign span_m4  = span - 32'd4;

    assign m_addr = u ? (base + (p ? 32'd4 : 32'd0)) : (base - (p ? span : span_m4));
    assign m_end  = u ? (base + (p ? span : span_m4)) : (base - (p ? 32'd4 : 32'd0));
    assign m_base = u ? (base + span) : (base - span);

    assign hsel = {l, ins[6], ins[5]};
    assign msel = {b22, l, ins[15]};

    always_comb begin
        o_res                = '0;
        o_res.address        = base;
        o_res.end_address    = base;
        o_res.new_base       = base;
        o_res.base_write     = 1'b0;
        o_res.base_reg       = ins[19:16];
        o_res.data_reg       = rd;
        o_res.access_kind    = KIND_STR;
        o_res.transfer_count = 5'd1;
        o_res.undefined      = 1'b0;
        o_res.unpredictable  = 1'b0;
        case (i_req.op)
            OP_SINGLE: begin
                if (p) begin
                    o_res.address = sum_single;
                    if (w) begin
                        o_res.new_base   = sum_single;
                        o_res.base_write = 1'b1;
                    end
                end else begin
                    o_res.new_base   = sum_single;
                    o_res.base_write = 1'b1;
                end
                // post-indexed with writeback selects the user-mode variant
                o_res.access_kind = {2'b00, b22, (!p && w), l};
                o_res.end_address = o_res.address;
            end
            OP_HALF: begin
                if (!p && !w) begin
                    o_res.new_base   = sum_half;
                    o_res.base_write = 1'b1;
                end else if (p) begin
                    o_res.address = sum_half;
                    if (w) begin
                        o_res.new_base   = sum_half;
                        o_res.base_write = 1'b1;
                    end
                end else begin
                    o_res.undefined = 1'b1;
                end
                case (hsel)
                    3'b001:  o_res.access_kind = KIND_STRH;
                    3'b010:  o_res.access_kind = KIND_LDRD;
                    3'b011:  o_res.access_kind = KIND_STRD;
                    3'b101:  o_res.access_kind = KIND_LDRH;
                    3'b110:  o_res.access_kind = KIND_LDRSB;
                    3'b111:  o_res.access_kind = KIND_LDRSH;
                    default: begin
                        o_res.access_kind = KIND_STR;
                        o_res.undefined   = 1'b1;
                    end
                endcase
                if (o_res.access_kind == KIND_LDRD) begin
                    o_res.unpredictable = rd[0] || (rd == LINK_REG)
                                        || (o_res.address[1:0] != 2'b00);
                end else if (o_res.access_kind == KIND_STRD) begin
                    o_res.unpredictable = rd[0] || (rd == LINK_REG)
                                        || (o_res.address[2:0] != 3'b000);
                end
                if (o_res.undefined) begin
                    o_res.base_write = 1'b0;
                    o_res.new_base   = base;
                end
                o_res.end_address = o_res.address;
            end
            OP_MULTI: begin
                o_res.transfer_count = list_cnt;
                o_res.address        = m_addr;
                o_res.end_address    = m_end;
                if (w) begin
                    o_res.new_base   = m_base;
                    o_res.base_write = 1'b1;
                end
                case (msel)
                    3'b000, 3'b001: o_res.access_kind = KIND_STM1;
                    3'b010, 3'b011: o_res.access_kind = KIND_LDM1;
                    3'b100, 3'b101: o_res.access_kind = KIND_STM2;
                    3'b110:         o_res.access_kind = KIND_LDM2;
                    default:        o_res.access_kind = KIND_LDM3;
                endcase
            end
            default: begin
                o_res.undefined = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/load_store_address_generator.sv
// load/store address generator top level: request register, compute, result register
//
//  channel   valid     stall     payload   direction
//  request   i_valid   o_stall   i_req     in
//  result    o_valid   i_stall   o_res     out
//
// one request per cycle while o_stall is low; each request passes the request register and then the result register
// the request register feeds lsag_calc, whose output is caught in the result register
// the request side stalls only when both registers are full and the result is stalled
// synchronous active-low reset empties both registers
module load_store_address_generator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lsag_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output lsag_pkg::t_res o_res
);
    import lsag_pkg::*;

    logic r_in_valid;
    logic n_in_valid;
    t_req r_in;
    logic r_out_valid;
    logic n_out_valid;
    t_res r_out;
    t_res calc_res;
    logic out_adv;
    logic in_adv;

    lsag_calc u_calc (
        .i_req (r_in),
        .o_res (calc_res)
    );

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;

    assign n_in_valid  = in_adv ? i_valid : r_in_valid;
    assign n_out_valid = out_adv ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_in <= i_req;
        end
        if (out_adv && r_in_valid) begin
            r_out <= calc_res;
        end
    end

    assign o_stall = !in_adv;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// File: rtl/lsag_checker.sv
// port-level checker for the load/store address generator, with its bind
`include "load_store_address_generator_defines.svh"

module lsag_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input lsag_pkg::t_req i_req,
    input logic           o_valid,
    input logic           i_stall,
    input lsag_pkg::t_res o_res
);
    import lsag_pkg::*;

    // no result right after reset
    `LSAG_ASSERT_RST(a_rst_empty, !i_rst_n, !o_valid)

    // request side stalls only behind a stalled result
    `LSAG_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)

    // a stalled result holds
    `LSAG_ASSERT_NXT(a_res_hold, o_valid && i_stall, o_valid && $stable(o_res))

    // a taken request shows up in the result register, through the request register, when the output moves
    `LSAG_ASSERT_NXT(a_latency, (i_valid && !o_stall) ##1 (!o_valid || !i_stall), o_valid && (o_res.base_reg == $past(i_req.instruction[19:16], 2)) && (o_res.data_reg == $past(i_req.instruction[15:12], 2)))

    // reserved class always flags undefined
    `LSAG_ASSERT_NXT(a_rsvd_undef, (i_valid && !o_stall && (i_req.op == OP_RSVD)) ##1 (!o_valid || !i_stall), o_valid && o_res.undefined)

endmodule

bind load_store_address_generator lsag_checker u_lsag_checker (.*);

// File: tb/lsag_access_checker.sv
// checker for the load/store address generator: predicts each request and compares results
module lsag_access_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  lsag_pkg::t_req i_req,
    input  logic           i_res_valid,
    input  logic           i_res_stall,
    input  lsag_pkg::t_res i_res,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import lsag_pkg::*;

    t_res access_q[$];
    t_res want;
    int   fails = 0;
    int   checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic logic [31:0] scaled_offset(logic [1:0] code, logic [4:0] amt,
                                                  logic [31:0] v, logic c);
        case (t_shift'(code))
            SH_LSL: return v << amt;
            SH_LSR: return (amt == 5'd0) ? 32'd0 : v >> amt;
            SH_ASR: return (amt == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
            // amount zero means rotate right extended through carry
            default: return (amt == 5'd0) ? {c, v[31:1]}
                                          : ((v >> amt) | (v << (6'd32 - {1'b0, amt})));
        endcase
    endfunction

    function automatic t_res predict_access(t_req r);
        t_res        e;
        logic [31:0] ins;
        logic [31:0] base;
        logic [31:0] off;
        logic [31:0] sum;
        logic [31:0] span;
        logic [31:0] amask;
        logic [4:0]  n;
        logic        p, u, b22, w, l;
        ins = r.instruction;
        base = r.base_value;
        p = ins[24];
        u = ins[23];
        b22 = ins[22];
        w = ins[21];
        l = ins[20];
        e.address = base;
        e.end_address = base;
        e.new_base = base;
        e.base_write = 1'b0;
        e.base_reg = ins[19:16];
        e.data_reg = ins[15:12];
        e.access_kind = KIND_STR;
        e.transfer_count = 5'd1;
        e.undefined = 1'b0;
        e.unpredictable = 1'b0;
        case (r.op)
            OP_SINGLE: begin
                off = ins[25] ? scaled_offset(ins[6:5], ins[11:7], r.offset_value,
                                              r.carry_flag)
                              : {20'd0, ins[11:0]};
                sum = u ? base + off : base - off;
                if (p) begin
                    e.address = sum;
                    if (w) begin
                        e.new_base = sum;
                        e.base_write = 1'b1;
                    end
                end else begin
                    e.new_base = sum;
                    e.base_write = 1'b1;
                end
                // byte adds 4, user-mode variant adds 2, load adds 1
                e.access_kind = {2'b00, b22, ~p & w, l};
                e.end_address = e.address;
            end
            OP_HALF: begin
                off = b22 ? {24'd0, ins[11:8], ins[3:0]} : r.offset_value;
                sum = u ? base + off : base - off;
                if (!p && !w) begin
                    e.new_base = sum;
                    e.base_write = 1'b1;
                end else if (p) begin
                    e.address = sum;
                    if (w) begin
                        e.new_base = sum;
                        e.base_write = 1'b1;
                    end
                end else begin
                    e.undefined = 1'b1;
                end
                case ({l, ins[6], ins[5]})
                    3'b001: e.access_kind = KIND_STRH;
                    3'b010: e.access_kind = KIND_LDRD;
                    3'b011: e.access_kind = KIND_STRD;
                    3'b101: e.access_kind = KIND_LDRH;
                    3'b110: e.access_kind = KIND_LDRSB;
                    3'b111: e.access_kind = KIND_LDRSH;
                    default: begin
                        e.access_kind = KIND_STR;
                        e.undefined = 1'b1;
                    end
                endcase
                if (e.access_kind == KIND_LDRD || e.access_kind == KIND_STRD) begin
                    amask = (e.access_kind == KIND_STRD) ? 32'd7 : 32'd3;
                    if (ins[12] || ins[15:12] == LINK_REG || (e.address & amask) != 0)
                        e.unpredictable = 1'b1;
                end
                if (e.undefined) begin
                    e.base_write = 1'b0;
                    e.new_base = base;
                end
                e.end_address = e.address;
            end
            OP_MULTI: begin
                n = 5'($countones(ins[15:0]));
                span = 32'(n) << 2;
                e.transfer_count = n;
                if (u) begin
                    e.address = p ? base + 32'd4 : base;
                    e.end_address = p ? base + span : base + span - 32'd4;
                    if (w) begin
                        e.new_base = base + span;
                        e.base_write = 1'b1;
                    end
                end else begin
                    e.address = p ? base - span : base - span + 32'd4;
                    e.end_address = p ? base - 32'd4 : base;
                    if (w) begin
                        e.new_base = base - span;
                        e.base_write = 1'b1;
                    end
                end
                case ({b22, l, ins[15]})
                    3'b000, 3'b001: e.access_kind = KIND_STM1;
                    3'b010, 3'b011: e.access_kind = KIND_LDM1;
                    3'b100, 3'b101: e.access_kind = KIND_STM2;
                    3'b110: e.access_kind = KIND_LDM2;
                    default: e.access_kind = KIND_LDM3;
                endcase
            end
            default: begin
                e.undefined = 1'b1;
            end
        endcase
        return e;
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall)
                access_q.push_back(predict_access(i_req));
            if (i_res_valid && !i_res_stall) begin
                if (access_q.size() == 0) begin
                    $error("result with no request outstanding: 0x%0h", i_res);
                    fails++;
                end else begin
                    want = access_q.pop_front();
                    check_field("address", want.address, i_res.address);
                    check_field("end_address", want.end_address, i_res.end_address);
                    check_field("new_base", want.new_base, i_res.new_base);
                    check_field("base_write", want.base_write, i_res.base_write);
                    check_field("base_reg", want.base_reg, i_res.base_reg);
                    check_field("data_reg", want.data_reg, i_res.data_reg);
                    check_field("access_kind", want.access_kind, i_res.access_kind);
                    check_field("transfer_count", want.transfer_count,
                                i_res.transfer_count);
                    check_field("undefined", want.undefined, i_res.undefined);
                    check_field("unpredictable", want.unpredictable, i_res.unpredictable);
                    checked++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= access_q.size();
        o_checked <= checked;
    end

endmodule

// File: tb/load_store_address_generator_tb.sv
// testbench top for the load/store address generator: clock, reset, stimulus and verdict
module load_store_address_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsag_pkg::*;

    localparam int N_RANDOM    = 1300;
    localparam int N_QUIET     = 150;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_res o_res;

    int   fail_count;
    int   pending;
    int   checked;
    int   cycle_count = 0;
    int   class_count[4] = '{0, 0, 0, 0};
    int   stall_left = 0;
    bit   quiet = 1'b0;

    load_store_address_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    lsag_access_checker access_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side stalls in bursts of random length
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic t_req req_of(logic [1:0] op, logic [31:0] ins, logic [31:0] base,
                                    logic [31:0] off, logic c);
        t_req r;
        r.op = op;
        r.instruction = ins;
        r.base_value = base;
        r.offset_value = off;
        r.carry_flag = c;
        return r;
    endfunction

    // called at a falling edge; returns at a falling edge after the request is taken
    task automatic send_request(t_req r);
        i_req <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        class_count[r.op]++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    initial begin
        t_req directed[$];
        t_req r;
        int   pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single word/byte: immediate and every scaled-offset form
        directed.push_back(req_of(OP_SINGLE, 32'h0191_2FFF, 32'hFFFF_FFFF, 32'h0, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0163_4001, 32'h0000_0000, 32'h0, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0070_F0FF, 32'h0000_1000, 32'h0, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0380_0F80, 32'h0000_0010, 32'h1, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0380_0020, 32'h0000_0010, 32'hFFFF_FFFF, 1'b1));
        directed.push_back(req_of(OP_SINGLE, 32'h0380_00A0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0300_0040, 32'h0000_0000, 32'h8000_0000, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0380_02C0, 32'h0000_0100, 32'h8000_00F0, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0380_0460, 32'h0000_0000, 32'h1234_5678, 1'b0));
        directed.push_back(req_of(OP_SINGLE, 32'h0380_0060, 32'h0000_0000, 32'h0000_0003, 1'b1));
        directed.push_back(req_of(OP_SINGLE, 32'h02A0_0060, 32'h0000_0040, 32'h0000_0003, 1'b0));
        // halfword/doubleword: each kind, undefined forms, doubleword hazards
        directed.push_back(req_of(OP_HALF, 32'h01E1_2FBF, 32'hFFFF_FFF0, 32'h0, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h01C0_30D0, 32'h0000_0100, 32'h0, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h01C0_E0D0, 32'h0000_0100, 32'h0, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h01C0_20D1, 32'h0000_0100, 32'h0, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h01C0_20F4, 32'h0000_0100, 32'h0, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h0010_20B0, 32'h0000_0005, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h0190_20D0, 32'h0000_0005, 32'h0000_0003, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h0030_20F0, 32'h0000_0005, 32'h0000_0003, 1'b0));
        directed.push_back(req_of(OP_HALF, 32'h0180_2090, 32'h0000_0005, 32'h0000_0003, 1'b0));
        // multiple: every kind, all four directions, full and empty lists
        directed.push_back(req_of(OP_MULTI, 32'h08A0_FFFF, 32'hFFFF_FFF0, 32'h0, 1'b0));
        directed.push_back(req_of(OP_MULTI, 32'h0990_0001, 32'h0000_0000, 32'h0, 1'b0));
        directed.push_back(req_of(OP_MULTI, 32'h0840_8000, 32'h0000_0000, 32'h0, 1'b0));
        directed.push_back(req_of(OP_MULTI, 32'h0970_00F0, 32'h0000_0000, 32'h0, 1'b0));
        directed.push_back(req_of(OP_MULTI, 32'h0850_8001, 32'h0000_0010, 32'h0, 1'b0));
        directed.push_back(req_of(OP_MULTI, 32'h08A0_0000, 32'h0000_0010, 32'h0, 1'b0));
        directed.push_back(req_of(OP_RSVD, 32'hFFFF_FFFF, 32'h0000_1234, 32'hFFFF_FFFF, 1'b1));
        foreach (directed[k])
            send_request(directed[k]);

        for (int k = 0; k < N_RANDOM; k++) begin
            quiet = (k >= N_RANDOM - N_QUIET);
            pick = $urandom_range(0, 19);
            r.op = (pick < 7) ? OP_SINGLE : (pick < 13) ? OP_HALF
                 : (pick < 19) ? OP_MULTI : OP_RSVD;
            r.instruction = $urandom();
            pick = $urandom_range(0, 7);
            r.base_value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
            pick = $urandom_range(0, 7);
            r.offset_value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
            r.carry_flag = $urandom_range(0, 1);
            case (r.op)
                OP_SINGLE: begin
                    // boost shift amount zero, where the special shift forms live
                    if ($urandom_range(0, 4) == 0)
                        r.instruction[11:7] = '0;
                end
                OP_HALF: begin
                    // aligned doubleword accesses half the time
                    if ($urandom_range(0, 1) == 0) begin
                        r.base_value[2:0] = '0;
                        r.offset_value[2:0] = '0;
                        r.instruction[2:0] = '0;
                    end
                end
                OP_MULTI: begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0)
                        r.instruction[15:0] = '0;
                    else if (pick < 6)
                        r.instruction[15:0] = r.instruction[15:0] & 16'($urandom())
                                              & 16'($urandom());
                end
                default: ;
            endcase
            send_request(r);
        end
        i_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("covered %0d requests: %0d single, %0d halfword/doubleword, %0d multiple,",
                 class_count[0] + class_count[1] + class_count[2] + class_count[3],
                 class_count[0], class_count[1], class_count[2]);
        $display("%0d reserved; %0d results compared field by field under gaps and stalls",
                 class_count[3], checked);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
